// File: hdl/mbpb_pkg.sv
`default_nettype none
package mbpb_pkg;

  localparam int CH_W       = 8;
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = FRAC_W + CH_W;
  localparam int SHIFT_W    = PROD_W - FRAC_SHIFT;

  // Counter width; the reported field is fixed at 24 bits
  localparam int COUNT_BITS  = 24;
  localparam int CNT_FIELD_W = 24;
  localparam int CNT_WIDE_W  = (COUNT_BITS > CNT_FIELD_W) ? COUNT_BITS : CNT_FIELD_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FRAC_W;

  localparam logic [CH_W-1:0] ALPHA_RESET = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_FRACTION = 3'd0,
    REG_BG_RED         = 3'd1,
    REG_BG_GREEN       = 3'd2,
    REG_BG_BLUE        = 3'd3,
    REG_ALPHA_VALUE    = 3'd4
  } cfg_reg_t;

endpackage
`default_nettype wire

// File: hdl/mbpb_pix_if.sv
`default_nettype none
interface mbpb_pix_if
  import mbpb_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] first_red;
  logic [CH_W-1:0] first_green;
  logic [CH_W-1:0] first_blue;
  logic [CH_W-1:0] second_red;
  logic [CH_W-1:0] second_green;
  logic [CH_W-1:0] second_blue;
  logic            last_pixel;

  modport source (
    output valid, first_red, first_green, first_blue,
           second_red, second_green, second_blue, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, first_red, first_green, first_blue,
           second_red, second_green, second_blue, last_pixel,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/mbpb_res_if.sv
`default_nettype none
interface mbpb_res_if
  import mbpb_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CH_W-1:0]        out_red;
  logic [CH_W-1:0]        out_green;
  logic [CH_W-1:0]        out_blue;
  logic [CH_W-1:0]        out_alpha;
  logic                   image_done;
  logic [CNT_FIELD_W-1:0] changed_count;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, image_done, changed_count,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, image_done, changed_count,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/mbpb_cfg_if.sv
`default_nettype none
interface mbpb_cfg_if
  import mbpb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/motion_blur_pixel_blend.sv
`default_nettype none
// Channel  Role  Handshake      Payload
// pixel    in    valid/ready    first_*/second_* RGB, last_pixel
// result   out   valid/ready    out_* RGBA, image_done, changed_count
// cfg      in    valid/ready    index, data (always ready)
//
// Two register stages: input register, then result register.
// One item per cycle sustained while result.ready stays high; the three 17x8 multipliers sit between the stages.
// rst (synchronous) clears valids, the counter and the configuration registers to their defaults.
// A stalled result holds its register; the input register keeps filling until both
// stages are full, then pixel.ready drops.
module motion_blur_pixel_blend
  import mbpb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mbpb_pix_if.sink   pixel,
  mbpb_res_if.source result,
  mbpb_cfg_if.sink   cfg
);

  // configuration registers
  logic [FRAC_W-1:0] blend_fraction;
  logic [CH_W-1:0]   bg_red;
  logic [CH_W-1:0]   bg_green;
  logic [CH_W-1:0]   bg_blue;
  logic [CH_W-1:0]   alpha_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_fraction <= '0;
      bg_red         <= '0;
      bg_green       <= '0;
      bg_blue        <= '0;
      alpha_value    <= ALPHA_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_BLEND_FRACTION: blend_fraction <= cfg.data;
        REG_BG_RED:         bg_red         <= cfg.data[CH_W-1:0];
        REG_BG_GREEN:       bg_green       <= cfg.data[CH_W-1:0];
        REG_BG_BLUE:        bg_blue        <= cfg.data[CH_W-1:0];
        REG_ALPHA_VALUE:    alpha_value    <= cfg.data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic            s1_valid;
  logic [CH_W-1:0] s1_r1, s1_g1, s1_b1, s1_r2, s1_g2, s1_b2;
  logic            s1_last;
  logic            s1_go;

  assign s1_go       = s1_valid && (!result.valid || result.ready);
  assign pixel.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      s1_r1   <= pixel.first_red;
      s1_g1   <= pixel.first_green;
      s1_b1   <= pixel.first_blue;
      s1_r2   <= pixel.second_red;
      s1_g2   <= pixel.second_green;
      s1_b2   <= pixel.second_blue;
      s1_last <= pixel.last_pixel;
    end
  end

  // blend
  logic [CH_W-1:0] bl_r, bl_g, bl_b;
  logic            nz_r, nz_g, nz_b;
  logic            is_bg;

  mbpb_channel u_red (
    .second(s1_r2), .bg(bg_red), .frac(blend_fraction), .result(bl_r), .nonzero(nz_r)
  );
  mbpb_channel u_green (
    .second(s1_g2), .bg(bg_green), .frac(blend_fraction), .result(bl_g), .nonzero(nz_g)
  );
  mbpb_channel u_blue (
    .second(s1_b2), .bg(bg_blue), .frac(blend_fraction), .result(bl_b), .nonzero(nz_b)
  );

  assign is_bg = (s1_r1 == bg_red) && (s1_g1 == bg_green) && (s1_b1 == bg_blue);

  // changed-pixel counter
  logic [COUNT_BITS-1:0]  counter;
  logic [COUNT_BITS-1:0]  cnt_base;
  logic [COUNT_BITS-1:0]  counter_next;
  logic [CNT_WIDE_W-1:0]  cnt_wide;
  logic [CNT_FIELD_W-1:0] cnt_report;

  always_comb begin
    cnt_base = counter;
    if (is_bg && (nz_r || nz_g || nz_b) && (counter != {COUNT_BITS{1'b1}})) begin
      cnt_base = counter + COUNT_BITS'(1);
    end
    cnt_wide   = CNT_WIDE_W'(cnt_base);
    cnt_report = (cnt_wide > CNT_WIDE_W'({CNT_FIELD_W{1'b1}})) ? {CNT_FIELD_W{1'b1}}
                                                              : cnt_wide[CNT_FIELD_W-1:0];
    counter_next = s1_last ? '0 : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (s1_go) begin
      counter <= counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (!result.valid || result.ready) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result.out_red       <= is_bg ? bl_r : s1_r1;
      result.out_green     <= is_bg ? bl_g : s1_g1;
      result.out_blue      <= is_bg ? bl_b : s1_b1;
      result.out_alpha     <= alpha_value;
      result.image_done    <= s1_last;
      result.changed_count <= s1_last ? cnt_report : '0;
    end
  end

  // checks
  a_count_zero_midimage: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.image_done |-> result.changed_count == '0)
    else $error("changed_count nonzero on a pixel that is not last");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> counter == '0)
    else $error("counter not cleared after last pixel");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_go && !s1_last |=> counter >= $past(counter))
    else $error("counter decreased inside an image");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result.valid && !result.ready |=> s1_valid && $stable(counter))
    else $error("input stage lost an item during output stall");

endmodule
`default_nettype wire

// File: hdl/mbpb_channel.sv
`default_nettype none
// One color channel: bg + fraction * (second - bg), magnitude truncated
// toward bg, clamped to the 8-bit range.
module mbpb_channel
  import mbpb_pkg::*;
(
  input  wire logic [CH_W-1:0]   second,
  input  wire logic [CH_W-1:0]   bg,
  input  wire logic [FRAC_W-1:0] frac,
  output logic      [CH_W-1:0]   result,
  output logic                   nonzero
);

  logic              up;
  logic [CH_W-1:0]   diff;
  logic [PROD_W-1:0] mag;
  logic [SHIFT_W-1:0] step;
  logic [SHIFT_W:0]  sum;

  always_comb begin
    up      = (second >= bg);
    diff    = up ? (second - bg) : (bg - second);
    mag     = PROD_W'(frac) * PROD_W'(diff);
    nonzero = (mag != '0);
    step    = mag[PROD_W-1:FRAC_SHIFT];
    sum     = (SHIFT_W+1)'(bg) + (SHIFT_W+1)'(step);
    if (up) begin
      // clamp at white
      result = (sum > (SHIFT_W+1)'({CH_W{1'b1}})) ? {CH_W{1'b1}} : sum[CH_W-1:0];
    end else begin
      // clamp at black
      result = (step > SHIFT_W'(bg)) ? '0 : (bg - step[CH_W-1:0]);
    end
  end

endmodule
`default_nettype wire

// File: verif/tb_motion_blur_pixel_blend.sv
`default_nettype none
module tb_motion_blur_pixel_blend;
  import mbpb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int GAP_PCT     = 36;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 80;

  typedef struct packed {
    logic [CH_W-1:0] first_red;
    logic [CH_W-1:0] first_green;
    logic [CH_W-1:0] first_blue;
    logic [CH_W-1:0] second_red;
    logic [CH_W-1:0] second_green;
    logic [CH_W-1:0] second_blue;
    logic            last_pixel;
  } pixel_pair_t;

  typedef struct packed {
    logic [CH_W-1:0]        out_red;
    logic [CH_W-1:0]        out_green;
    logic [CH_W-1:0]        out_blue;
    logic [CH_W-1:0]        out_alpha;
    logic                   image_done;
    logic [CNT_FIELD_W-1:0] changed_count;
  } blended_px_t;

  class blend_scoreboard;
    logic [FRAC_W-1:0]     fraction;
    logic [CH_W-1:0]       bg_r, bg_g, bg_b, alpha;
    logic [COUNT_BITS-1:0] changed;
    blended_px_t           blended_q[$];
    int                    errors;

    function new();
      fraction = '0;
      bg_r     = '0;
      bg_g     = '0;
      bg_b     = '0;
      alpha    = ALPHA_RESET;
      changed  = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BLEND_FRACTION: fraction = data[FRAC_W-1:0];
        REG_BG_RED:         bg_r = data[CH_W-1:0];
        REG_BG_GREEN:       bg_g = data[CH_W-1:0];
        REG_BG_BLUE:        bg_b = data[CH_W-1:0];
        REG_ALPHA_VALUE:    alpha = data[CH_W-1:0];
        default: ;
      endcase
    endfunction

    // Move bg toward second by fraction, truncating the step toward bg
    function logic [CH_W-1:0] blend_channel(logic [CH_W-1:0] second, logic [CH_W-1:0] bg,
                                            inout bit moved);
      logic [PROD_W-1:0]  mag;
      logic [SHIFT_W-1:0] step;
      logic [SHIFT_W:0]   sum;
      if (second >= bg) begin
        mag  = PROD_W'(fraction) * PROD_W'(second - bg);
        step = mag[PROD_W-1:FRAC_SHIFT];
        sum  = (SHIFT_W+1)'(bg) + (SHIFT_W+1)'(step);
      end else begin
        mag  = PROD_W'(fraction) * PROD_W'(bg - second);
        step = mag[PROD_W-1:FRAC_SHIFT];
        sum  = (step > SHIFT_W'(bg)) ? '0 : ((SHIFT_W+1)'(bg) - (SHIFT_W+1)'(step));
      end
      if (mag != '0) moved = 1'b1;
      return (sum > (SHIFT_W+1)'({CH_W{1'b1}})) ? {CH_W{1'b1}} : sum[CH_W-1:0];
    endfunction

    function void note_pixel(pixel_pair_t p);
      blended_px_t           e;
      bit                    moved;
      logic [CNT_WIDE_W-1:0] wide;
      moved = 1'b0;
      if (p.first_red != bg_r || p.first_green != bg_g || p.first_blue != bg_b) begin
        e.out_red   = p.first_red;
        e.out_green = p.first_green;
        e.out_blue  = p.first_blue;
      end else begin
        e.out_red   = blend_channel(p.second_red, bg_r, moved);
        e.out_green = blend_channel(p.second_green, bg_g, moved);
        e.out_blue  = blend_channel(p.second_blue, bg_b, moved);
        if (moved && changed != {COUNT_BITS{1'b1}}) changed++;
      end
      e.out_alpha  = alpha;
      e.image_done = p.last_pixel;
      if (p.last_pixel) begin
        wide = CNT_WIDE_W'(changed);
        e.changed_count = (wide > CNT_WIDE_W'({CNT_FIELD_W{1'b1}})) ? {CNT_FIELD_W{1'b1}}
                                                                    : wide[CNT_FIELD_W-1:0];
        changed = '0;
      end else begin
        e.changed_count = '0;
      end
      blended_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(blended_px_t got);
      blended_px_t e;
      if (blended_q.size() == 0) begin
        $error("result item with no pixel pending");
        errors++;
        return;
      end
      e = blended_q.pop_front();
      compare_field("out_red", 32'(e.out_red), 32'(got.out_red));
      compare_field("out_green", 32'(e.out_green), 32'(got.out_green));
      compare_field("out_blue", 32'(e.out_blue), 32'(got.out_blue));
      compare_field("out_alpha", 32'(e.out_alpha), 32'(got.out_alpha));
      compare_field("image_done", 32'(e.image_done), 32'(got.image_done));
      compare_field("changed_count", 32'(e.changed_count), 32'(got.changed_count));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   pixels_accepted;
  int   hold_left;
  bit   hold_done;
  bit   steady;

  blend_scoreboard sb = new();

  mbpb_pix_if pix_if();
  mbpb_res_if res_if();
  mbpb_cfg_if cfg_if();

  motion_blur_pixel_blend u_top (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    pixel_pair_t seen_px;
    blended_px_t seen_res;
    if (!rst) begin
      if (pix_if.valid && pix_if.ready) begin
        seen_px.first_red    = pix_if.first_red;
        seen_px.first_green  = pix_if.first_green;
        seen_px.first_blue   = pix_if.first_blue;
        seen_px.second_red   = pix_if.second_red;
        seen_px.second_green = pix_if.second_green;
        seen_px.second_blue  = pix_if.second_blue;
        seen_px.last_pixel   = pix_if.last_pixel;
        sb.note_pixel(seen_px);
        pixels_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        seen_res.out_red       = res_if.out_red;
        seen_res.out_green     = res_if.out_green;
        seen_res.out_blue      = res_if.out_blue;
        seen_res.out_alpha     = res_if.out_alpha;
        seen_res.image_done    = res_if.image_done;
        seen_res.changed_count = res_if.changed_count;
        sb.check_result(seen_res);
      end
    end
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < GAP_PCT);
  endfunction

  // Result side: random stalls, plus one long hold-off to back up the pipeline
  initial begin
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_if.ready <= 1'b0;
      end else begin
        if (!hold_done && pixels_accepted >= HOLD_AT) begin
          hold_left = HOLD_LEN;
          hold_done = 1'b1;
        end
        if (hold_left > 0) begin
          hold_left--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= !take_gap();
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(input pixel_pair_t p);
    while (take_gap()) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.first_red    <= p.first_red;
    pix_if.first_green  <= p.first_green;
    pix_if.first_blue   <= p.first_blue;
    pix_if.second_red   <= p.second_red;
    pix_if.second_green <= p.second_green;
    pix_if.second_blue  <= p.second_blue;
    pix_if.last_pixel   <= p.last_pixel;
    pix_if.valid        <= 1'b1;
    do @(posedge clk); while (!pix_if.ready);
    @(negedge clk);
  endtask

  task automatic send_px(input logic [CH_W-1:0] r1, g1, b1, r2, g2, b2,
                         input logic last);
    send_pixel('{r1, g1, b1, r2, g2, b2, last});
  endtask

  // Drop valid and let the pipeline empty before touching registers
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (sb.blended_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Narrow registers get random junk in the unused upper data bits
  function automatic logic [CFG_DATA_W-1:0] pad8(input logic [CH_W-1:0] v);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[CH_W-1:0] = v;
    return d;
  endfunction

  task automatic apply_setting(input logic [FRAC_W-1:0] frac,
                               input logic [CH_W-1:0] r, g, b, a);
    write_reg(REG_BLEND_FRACTION, frac);
    write_reg(REG_BG_RED, pad8(r));
    write_reg(REG_BG_GREEN, pad8(g));
    write_reg(REG_BG_BLUE, pad8(b));
    write_reg(REG_ALPHA_VALUE, pad8(a));
  endtask

  function automatic logic [CH_W-1:0] pick_bg();
    case ($urandom_range(3))
      0: return '0;
      1: return {CH_W{1'b1}};
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  task automatic random_setting();
    logic [FRAC_W-1:0] frac;
    case ($urandom_range(5))
      0: frac = '0;
      1: frac = 17'd65536;
      2: frac = {FRAC_W{1'b1}};
      3: frac = FRAC_W'($urandom_range(65536));
      4: frac = FRAC_W'($urandom_range(131071));
      default: frac = FRAC_W'($urandom_range(255));
    endcase
    apply_setting(frac, pick_bg(), pick_bg(), pick_bg(), CH_W'($urandom_range(255)));
    if ($urandom_range(1))
      write_reg(CFG_IDX_W'($urandom_range(7, REG_ALPHA_VALUE + 1)), CFG_DATA_W'($urandom));
  endtask

  // Mostly background-matching foregrounds so the blend path dominates
  function automatic pixel_pair_t random_pixel();
    pixel_pair_t p;
    int          kind;
    kind = $urandom_range(99);
    p.second_red   = CH_W'($urandom_range(255));
    p.second_green = CH_W'($urandom_range(255));
    p.second_blue  = CH_W'($urandom_range(255));
    if ($urandom_range(7) == 0) begin
      p.second_red   = sb.bg_r;
      p.second_green = sb.bg_g;
      p.second_blue  = sb.bg_b;
    end
    if (kind < 80) begin
      p.first_red   = sb.bg_r;
      p.first_green = sb.bg_g;
      p.first_blue  = sb.bg_b;
      if (kind >= 65) begin
        case ($urandom_range(2))
          0: p.first_red ^= CH_W'(1 << $urandom_range(CH_W-1));
          1: p.first_green ^= CH_W'(1 << $urandom_range(CH_W-1));
          default: p.first_blue ^= CH_W'(1 << $urandom_range(CH_W-1));
        endcase
        p.first_red ^= (kind == 65) ? CH_W'(1) : '0;
      end
    end else begin
      p.first_red   = CH_W'($urandom_range(255));
      p.first_green = CH_W'($urandom_range(255));
      p.first_blue  = CH_W'($urandom_range(255));
    end
    p.last_pixel = ($urandom_range(19) == 0);
    return p;
  endfunction

  initial begin
    rst             = 1'b1;
    steady          = 1'b0;
    pixels_accepted = 0;
    pix_if.valid        = 1'b0;
    pix_if.first_red    = '0;
    pix_if.first_green  = '0;
    pix_if.first_blue   = '0;
    pix_if.second_red   = '0;
    pix_if.second_green = '0;
    pix_if.second_blue  = '0;
    pix_if.last_pixel   = 1'b0;
    res_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting: zero fraction, black background
    send_px(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    send_px(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_px(8'd0, 8'd0, 8'd1, 8'd9, 8'd9, 8'd9, 1'b1);
    drain();

    // Unit fraction: output follows second frame
    apply_setting(17'd65536, 8'd128, 8'd128, 8'd128, 8'd0);
    write_reg(CFG_IDX_W'(REG_ALPHA_VALUE + 1), '1);
    send_px(8'd128, 8'd128, 8'd128, 8'd255, 8'd0, 8'd128, 1'b0);
    send_px(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
    send_px(8'd127, 8'd128, 8'd128, 8'd1, 8'd2, 8'd3, 1'b0);
    send_px(8'd128, 8'd128, 8'd128, 8'd200, 8'd100, 8'd50, 1'b1);
    drain();

    // Fraction near two: saturation at both ends
    apply_setting({FRAC_W{1'b1}}, 8'd100, 8'd200, 8'd50, 8'd77);
    send_px(8'd100, 8'd200, 8'd50, 8'd255, 8'd255, 8'd255, 1'b0);
    send_px(8'd100, 8'd200, 8'd50, 8'd0, 8'd0, 8'd0, 1'b0);
    send_px(8'd100, 8'd200, 8'd50, 8'd101, 8'd199, 8'd51, 1'b0);
    send_px(8'd100, 8'd200, 8'd50, 8'd100, 8'd200, 8'd50, 1'b1);
    drain();

    // Tiny fraction: counted although the color does not move
    apply_setting(17'd1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_px(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_px(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_px(8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 1'b1);
    drain();

    // Half fraction: truncation toward background
    apply_setting(17'd32768, 8'd0, 8'd0, 8'd0, 8'd170);
    send_px(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd255, 1'b0);
    send_px(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_px(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_setting();
      steady = (ph == 3);
      repeat (250) send_pixel(random_pixel());
      steady = 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
